>>> hw/rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Types and constants shared by the sorted key table and its cells.
// ----------------------------------------------------------------------------
package skt_pkg;

    // Fixed field widths of the stream payloads
    localparam int OP_W        = 2;
    localparam int KEY_W       = 32;
    localparam int INDEX_W     = 4;
    localparam int STATUS_W    = 2;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 4;
    localparam int COUNT_W     = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_READ   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic insert;
        logic descending;
    } cell_ctl_t;

endpackage

>>> hw/rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell
// One entry of the sorted table: holds a key, compares it with the operand
// and takes either the new key or its left neighbor's key on an insert.
// ----------------------------------------------------------------------------
module skt_cell #(
    parameter int KEY_BITS = 32,
    parameter int CNT_W    = 5,
    parameter int IDX      = 0
) (
    input  logic                  clk,
    input  skt_pkg::cell_ctl_t    ctl,
    input  logic [CNT_W-1:0]      count,
    input  logic [KEY_BITS-1:0]   key_in,
    input  logic [KEY_BITS-1:0]   left_key,
    input  logic                  ins_seen_in,
    output logic                  ins_seen_out,
    input  logic                  hit_seen_in,
    output logic                  hit_seen_out,
    output logic                  slot_here,
    output logic                  hit_here,
    output logic [KEY_BITS-1:0]   key_out
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                key_we;
    logic                valid;
    logic                at_end;
    logic                after;
    logic                moves;
    logic                eq;

    always_comb
    begin
        valid  = MY_IDX < count;
        at_end = MY_IDX == count;
        after  = ctl.descending ? (key_reg < key_in) : (key_reg > key_in);
        moves  = valid && after;
        eq     = valid && (key_reg == key_in);

        // The first cell whose key must follow the new key becomes its slot;
        // with no such cell the key lands just past the last entry.
        slot_here    = !ins_seen_in && (moves || at_end);
        ins_seen_out = ins_seen_in || moves;

        hit_here     = eq && !hit_seen_in;
        hit_seen_out = hit_seen_in || eq;

        key_we   = 1'b0;
        key_next = key_reg;
        if (ctl.insert)
        begin
            if (slot_here)
            begin
                key_we   = 1'b1;
                key_next = key_in;
            end
            else if (ins_seen_in && (valid || at_end))
            begin
                key_we   = 1'b1;
                key_next = left_key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_reg <= key_next;
        end
    end

    assign key_out = key_reg;

endmodule

>>> hw/rtl/sorted_key_table_top.sv
// ----------------------------------------------------------------------------
// sorted_key_table_top
// Table of up to DEPTH unsigned keys kept in sorted order by a row of cells.
// ----------------------------------------------------------------------------
// Each input transfer carries one operation: insert a key after all equal
// keys, find the first equal key, read the entry at an index, or drop the
// last entry. Each operation gives exactly one output transfer with status,
// value, position and the entry count after the operation.
// The cells compare the operand in parallel and an insert shifts the later
// entries one cell up in the same cycle, so a new transfer can be accepted
// every cycle while the output is not stalled. The result is written to the
// output register when its transfer is accepted. The combinational path is the
// first-match chain that runs through all DEPTH cells.
// cfg_wdata sets the order (0 ascending, 1 descending) on cfg_we; the user
// must write it only while the table is idle; the block does not enforce this.
// Reset empties the table and selects ascending order; no clearing pass is
// needed since entries past the count are never read.
// When the receiver stalls, the output register holds its result and
// s_axis_tready stays low until that result is taken.
// ----------------------------------------------------------------------------
module sorted_key_table_top #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] op, [33:2] key, [37:34] index, [39:38] zero
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [33:2] value, [37:34] position, [42:38] count, [47:43] zero
    output logic [47:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = skt_pkg::POS_W;
    localparam int INDEX_W = skt_pkg::INDEX_W;
    localparam int VALUE_W = skt_pkg::VALUE_W;
    localparam int COUNT_W = skt_pkg::COUNT_W;
    localparam int CMP_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int RD_N    = (DEPTH < (1 << INDEX_W)) ? DEPTH : (1 << INDEX_W);

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   desc_reg;
    logic                   out_valid_reg;
    logic [47:0]            out_data_reg;

    skt_pkg::op_t           op;
    logic [KEY_BITS-1:0]    key_ext;
    logic [INDEX_W-1:0]     index;
    logic                   accept;
    logic                   full;
    logic                   empty;
    skt_pkg::cell_ctl_t     ctl;

    logic [DEPTH:0]         ins_seen;
    logic [DEPTH:0]         hit_seen;
    logic [DEPTH-1:0]       slot_here;
    logic [DEPTH-1:0]       hit_here;
    logic [KEY_BITS-1:0]    cell_key [DEPTH];

    logic [POS_W-1:0]       slot_pos;
    logic [POS_W-1:0]       hit_pos;
    logic [KEY_BITS-1:0]    rd_key;
    logic                   rd_ok;
    skt_pkg::status_t       status;
    logic [VALUE_W-1:0]     value;
    logic [POS_W-1:0]       position;

    assign op      = skt_pkg::op_t'(s_axis_tdata[1:0]);
    assign key_ext = KEY_BITS'(s_axis_tdata[33:2]);
    assign index   = s_axis_tdata[37:34];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = count_reg == CNT_W'(DEPTH);
    assign empty         = count_reg == '0;

    assign ctl.insert     = accept && (op == skt_pkg::OP_INSERT) && !full;
    assign ctl.descending = desc_reg;

    assign ins_seen[0] = 1'b0;
    assign hit_seen[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [KEY_BITS-1:0] left_key;

        if (g == 0)
        begin : g_first
            assign left_key = cell_key[0];
        end
        else
        begin : g_rest
            assign left_key = cell_key[g-1];
        end

        skt_cell #(
            .KEY_BITS (KEY_BITS),
            .CNT_W    (CNT_W),
            .IDX      (g)
        ) u_cell (
            .clk          (clk),
            .ctl          (ctl),
            .count        (count_reg),
            .key_in       (key_ext),
            .left_key     (left_key),
            .ins_seen_in  (ins_seen[g]),
            .ins_seen_out (ins_seen[g+1]),
            .hit_seen_in  (hit_seen[g]),
            .hit_seen_out (hit_seen[g+1]),
            .slot_here    (slot_here[g]),
            .hit_here     (hit_here[g]),
            .key_out      (cell_key[g])
        );
    end

    // At most one cell flags the slot and one flags the hit, so an OR of
    // their indexes gives the position.
    always_comb
    begin
        slot_pos = '0;
        hit_pos  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_pos = slot_pos | (slot_here[i] ? POS_W'(i) : '0);
            hit_pos  = hit_pos  | (hit_here[i]  ? POS_W'(i) : '0);
        end

        rd_key = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (INDEX_W'(i) == index)
            begin
                rd_key = cell_key[i];
            end
        end
        rd_ok = CMP_W'(index) < CMP_W'(count_reg);
    end

    always_comb
    begin
        status     = skt_pkg::ST_OK;
        value      = '0;
        position   = '0;
        count_next = count_reg;
        unique case (op)
            skt_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status = skt_pkg::ST_FULL;
                end
                else
                begin
                    position   = slot_pos;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            skt_pkg::OP_FIND:
            begin
                if (hit_seen[DEPTH])
                begin
                    value    = VALUE_W'(key_ext);
                    position = hit_pos;
                end
                else
                begin
                    status = skt_pkg::ST_MISS;
                end
            end
            skt_pkg::OP_READ:
            begin
                if (rd_ok)
                begin
                    value    = VALUE_W'(rd_key);
                    position = index;
                end
                else
                begin
                    status = skt_pkg::ST_MISS;
                end
            end
            skt_pkg::OP_REMOVE:
            begin
                if (empty)
                begin
                    status = skt_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status = skt_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            desc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                desc_reg <= cfg_wdata;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {5'b0, COUNT_W'(count_next), position, value, status};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted key table testbench
// Streams insert, find, read and remove operations into the table. A
// scoreboard keeps its own sorted copy of the table and checks each result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TABLE_DEPTH    = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 200;
    localparam int PHASE_ITEMS    = 150;
    localparam int NUM_PHASES     = 6;

    typedef struct packed {
        skt_pkg::status_t              status;
        logic [skt_pkg::VALUE_W-1:0]   value;
        logic [skt_pkg::POS_W-1:0]     position;
        logic [skt_pkg::COUNT_W-1:0]   count;
    } table_result_t;

    // Keeps a sorted copy of the table and the results it must produce.
    class key_table_scoreboard;
        logic [skt_pkg::KEY_W-1:0] stored[TABLE_DEPTH];
        int unsigned               count;
        bit                        descending;
        table_result_t             results[$];
        int                        errors;

        function new();
            count      = 0;
            descending = 1'b0;
            errors     = 0;
        endfunction

        function void set_order(bit desc);
            descending = desc;
        endfunction

        function int pending();
            return results.size();
        endfunction

        // True when a stored entry must stand after the new key.
        function bit stands_after(logic [skt_pkg::KEY_W-1:0] entry,
                                  logic [skt_pkg::KEY_W-1:0] key);
            return descending ? (entry < key) : (entry > key);
        endfunction

        function void note_input(skt_pkg::op_t op, logic [skt_pkg::KEY_W-1:0] key,
                                 logic [skt_pkg::INDEX_W-1:0] idx);
            table_result_t r;
            int            slot;
            r.status   = skt_pkg::ST_OK;
            r.value    = '0;
            r.position = '0;
            r.count    = '0;
            case (op)
                skt_pkg::OP_INSERT:
                begin
                    if (count >= TABLE_DEPTH)
                    begin
                        r.status = skt_pkg::ST_FULL;
                    end
                    else
                    begin
                        slot = count;
                        for (int i = 0; i < count; i++)
                        begin
                            if (stands_after(stored[i], key))
                            begin
                                slot = i;
                                break;
                            end
                        end
                        for (int i = count; i > slot; i--)
                            stored[i] = stored[i-1];
                        stored[slot] = key;
                        count++;
                        r.position = slot[skt_pkg::POS_W-1:0];
                    end
                end
                skt_pkg::OP_FIND:
                begin
                    r.status = skt_pkg::ST_MISS;
                    for (int i = 0; i < count; i++)
                    begin
                        if (stored[i] == key)
                        begin
                            r.status   = skt_pkg::ST_OK;
                            r.value    = key;
                            r.position = i[skt_pkg::POS_W-1:0];
                            break;
                        end
                    end
                end
                skt_pkg::OP_READ:
                begin
                    if (idx < count)
                    begin
                        r.value    = stored[idx];
                        r.position = idx;
                    end
                    else
                    begin
                        r.status = skt_pkg::ST_MISS;
                    end
                end
                default:
                begin
                    if (count == 0)
                        r.status = skt_pkg::ST_EMPTY;
                    else
                        count--;
                end
            endcase
            r.count = count[skt_pkg::COUNT_W-1:0];
            results.push_back(r);
        endfunction

        function void check_result(logic [skt_pkg::OUT_TDATA_W-1:0] t);
            table_result_t want;
            if (results.size() == 0)
            begin
                $error("result with no operation waiting: tdata %h", t);
                errors++;
                return;
            end
            want = results.pop_front();
            if (t[1:0] != want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, t[1:0]);
                errors++;
            end
            if (t[33:2] != want.value)
            begin
                $error("value: expected %h, actual %h", want.value, t[33:2]);
                errors++;
            end
            if (t[37:34] != want.position)
            begin
                $error("position: expected %0d, actual %0d", want.position, t[37:34]);
                errors++;
            end
            if (t[42:38] != want.count)
            begin
                $error("count: expected %0d, actual %0d", want.count, t[42:38]);
                errors++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [skt_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [skt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            cfg_we = 1'b0;
    logic                            cfg_wdata = 1'b0;

    key_table_scoreboard sb;
    bit                  no_idle = 1'b0;
    bit                  hold_rx = 1'b0;

    sorted_key_table_top #(
        .DEPTH    (TABLE_DEPTH),
        .KEY_BITS (skt_pkg::KEY_W)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Both sides of every transfer are recorded at the edge that completes it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(skt_pkg::op_t'(s_axis_tdata[1:0]), s_axis_tdata[33:2],
                              s_axis_tdata[37:34]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // Receiver: random backpressure, or a long hold-off when asked for.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
            end
            else
            begin
                m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 30);
            end
        end
    end

    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_op(skt_pkg::op_t op, logic [skt_pkg::KEY_W-1:0] key,
                           logic [skt_pkg::INDEX_W-1:0] idx);
        while (!no_idle && $urandom_range(99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, idx, key, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic write_order(bit desc);
        cfg_we    <= 1'b1;
        cfg_wdata <= desc;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_order(desc);
    endtask

    // One edge first so that the last accepted transfer is already queued.
    task automatic wait_drained();
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    function automatic logic [skt_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return '1;
        else if (r < 40)
            return skt_pkg::KEY_W'($urandom_range(7));
        else
            return $urandom();
    endfunction

    function automatic logic [skt_pkg::KEY_W-1:0] pick_search_key();
        if (sb.count > 0 && $urandom_range(99) < 55)
            return sb.stored[$urandom_range(sb.count - 1)];
        return pick_key();
    endfunction

    initial
    begin
        bit phase_order[NUM_PHASES];
        int insert_wt[NUM_PHASES];
        int remove_wt[NUM_PHASES];
        int r;
        skt_pkg::op_t op;

        phase_order = '{1, 0, 1, 0, 0, 1};
        insert_wt   = '{60, 25, 45, 20, 55, 35};
        remove_wt   = '{10, 35, 20, 45, 15, 25};

        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_order(1'b0);

        // Empty table: remove, find and read all fail.
        send_op(skt_pkg::OP_REMOVE, '0, '0);
        send_op(skt_pkg::OP_FIND, '1, '0);
        send_op(skt_pkg::OP_READ, '0, 4'd15);
        // Extremes and an equal key, which goes after the one already held.
        send_op(skt_pkg::OP_INSERT, '1, '0);
        send_op(skt_pkg::OP_INSERT, '0, '0);
        send_op(skt_pkg::OP_INSERT, 32'd5, '0);
        send_op(skt_pkg::OP_INSERT, 32'd5, '1);
        send_op(skt_pkg::OP_FIND, 32'd5, '0);
        send_op(skt_pkg::OP_FIND, 32'd1, '0);
        send_op(skt_pkg::OP_READ, '0, 4'd3);
        send_op(skt_pkg::OP_READ, '0, 4'd4);
        // Fill to capacity, then one insert too many.
        repeat (TABLE_DEPTH - 4) send_op(skt_pkg::OP_INSERT, $urandom(), '0);
        send_op(skt_pkg::OP_INSERT, 32'd9, '0);
        send_op(skt_pkg::OP_READ, '0, 4'd15);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // The order may change while the table still holds entries.
            write_order(phase_order[p]);
            no_idle = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 1 && n == 30)
                    hold_rx = 1'b1;
                r = $urandom_range(99);
                if (r < insert_wt[p])
                    op = skt_pkg::OP_INSERT;
                else if (r < insert_wt[p] + remove_wt[p])
                    op = skt_pkg::OP_REMOVE;
                else if (r[0])
                    op = skt_pkg::OP_FIND;
                else
                    op = skt_pkg::OP_READ;
                if (op == skt_pkg::OP_FIND)
                    send_op(op, pick_search_key(), 4'($urandom_range(15)));
                else
                    send_op(op, pick_key(), 4'($urandom_range(15)));
            end
            s_axis_tvalid <= 1'b0;
            no_idle = 1'b0;
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
